// ----- sv/lbb_pkg.sv -----
// package: widths, codes and shared types of the byte-budget lru policy engine
`timescale 1ns / 1ps
package lbb_pkg;
  localparam int ENTRIES = 16;
  localparam int SW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [31:0] BUDGET_RESET = 32'd16777216;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_TRIM   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_HIT     = 3'd0,
    K_MISS    = 3'd1,
    K_STORED  = 3'd2,
    K_PRESENT = 3'd3,
    K_REJECT  = 3'd4,
    K_EVICT   = 3'd5,
    K_DONE    = 3'd6
  } kind_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] source_key;
    logic [31:0] piece_number;
    logic [31:0] piece_size;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [32:0] held_bytes;
    logic [4:0]  held_entries;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] eviction_total;
    logic        last;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture request, run tag compare
    logic decide;  // act on the compare result
    logic evict;   // evict the oldest entry
    logic store;   // write the new entry
    logic emit;    // load output register
    kind_t kind;
    logic  last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic hit;
    logic full;
    logic oversize;
    logic over_budget;
    logic empty;
  } sts_t;
endpackage

// ----- sv/lbb_if.sv -----
// valid/ready channel interfaces for request and result items
`timescale 1ns / 1ps
interface lbb_req_if;
  import lbb_pkg::*;
  logic valid;
  logic ready;
  logic [1:0]  op;
  logic [63:0] source_key;
  logic [31:0] piece_number;
  logic [31:0] piece_size;
  modport source (output valid, op, source_key, piece_number, piece_size, input ready);
  modport sink (input valid, op, source_key, piece_number, piece_size, output ready);
endinterface

interface lbb_rsp_if;
  logic valid;
  logic ready;
  logic [2:0]  kind;
  logic [3:0]  slot;
  logic [32:0] held_bytes;
  logic [4:0]  held_entries;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  logic [31:0] eviction_total;
  logic        last;
  modport source (output valid, kind, slot, held_bytes, held_entries, hit_total,
                  miss_total, eviction_total, last, input ready);
  modport sink (input valid, kind, slot, held_bytes, held_entries, hit_total,
                miss_total, eviction_total, last, output ready);
endinterface

// ----- sv/lru_byte_budget_cache_policy.sv -----
// top level: lru byte-budget replacement engine with result register
// the request is captured in S_IDLE and decided in S_DEC (trim passes S_CHECK);
// results come from the register loaded in S_EMIT, further ones after S_STORE or
// S_CHECK; a new item is taken only after the item's last result is accepted;
// result stalls hold the flow, and the serial evict loop sets the rate
// reset (rst, synchronous): table empty, byte total and counters zero, budget 16777216
`timescale 1ns / 1ps
module lru_byte_budget_cache_policy (
  input  logic        clk,
  input  logic        rst,
  lbb_req_if.sink     req,
  lbb_rsp_if.source   rsp,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import lbb_pkg::*;

  logic [31:0] budget;
  req_t  req_w;
  cmd_t  cmd;
  sts_t  sts;
  rsp_t  out_q;
  logic  out_valid, in_ready;

  // budget register: to be written only while no item is in flight; the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) budget <= BUDGET_RESET;
    else if (cfg_we) budget <= cfg_wdata;
  end

  assign req_w = '{op: req.op, source_key: req.source_key,
                   piece_number: req.piece_number, piece_size: req.piece_size};

  // controller: one command per cycle, then a result step once the register is free
  lbb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(req.valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(rsp.ready), .sts(sts), .cmd(cmd)
  );

  // datapath: table, ranks, totals and the result register
  lbb_datapath u_dp (
    .clk(clk), .rst(rst), .budget(budget), .req(req_w), .cmd(cmd),
    .sts(sts), .rsp(out_q)
  );

  assign req.ready = in_ready;
  assign rsp.valid = out_valid;
  assign rsp.kind = out_q.kind;
  assign rsp.slot = out_q.slot;
  assign rsp.held_bytes = out_q.held_bytes;
  assign rsp.held_entries = out_q.held_entries;
  assign rsp.hit_total = out_q.hit_total;
  assign rsp.miss_total = out_q.miss_total;
  assign rsp.eviction_total = out_q.eviction_total;
  assign rsp.last = out_q.last;

  // byte total never exceeds budget after a store chain ends
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.last && (rsp.kind == K_STORED || rsp.kind == K_EVICT))
      |-> rsp.held_bytes <= {1'b0, budget})
    else $error("held bytes over budget after insert");
  // an item is never taken while a result waits
  assert property (@(posedge clk) disable iff (rst) rsp.valid |-> !req.ready)
    else $error("item accepted while result pending");
  // entry count stays within the table
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.held_entries <= 5'(ENTRIES))
    else $error("held entries out of range");
  // a stalled result holds still
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable({rsp.kind, rsp.slot, rsp.last})))
    else $error("result changed while stalled");
endmodule

// ----- sv/lbb_datapath.sv -----
// datapath: tag table, age ranks, byte total, counters and result register
`timescale 1ns / 1ps
module lbb_datapath (
  input  logic            clk,
  input  logic            rst,
  input  logic [31:0]     budget,
  input  lbb_pkg::req_t   req,
  input  lbb_pkg::cmd_t   cmd,
  output lbb_pkg::sts_t   sts,
  output lbb_pkg::rsp_t   rsp
);
  import lbb_pkg::*;

  logic [ENTRIES-1:0] valid;
  logic [63:0] tag_src [ENTRIES];
  logic [31:0] tag_piece [ENTRIES];
  logic [31:0] size [ENTRIES];
  logic [SW-1:0] rank [ENTRIES];
  logic [32:0] bytes;
  logic [31:0] hits, misses, evicts;
  req_t r;

  // compare results registered with the request
  logic hit;
  logic [SW-1:0] hit_slot, free_slot;
  logic full;

  logic [ENTRIES-1:0] match_c;
  logic [SW-1:0] hs_c, fs_c, os_c;
  logic [CW-1:0] count;
  logic [SW-1:0] out_slot;
  logic no_slot;

  always_comb begin
    hs_c = '0;
    fs_c = '0;
    os_c = '0;
    count = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match_c[i] = valid[i] && tag_src[i] == req.source_key && tag_piece[i] == req.piece_number;
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_c[i]) hs_c = SW'(i);
      if (!valid[i]) fs_c = SW'(i);
    end
    // oldest has rank count-1; ranks are distinct
    for (int i = 0; i < ENTRIES; i++) count = count + CW'(valid[i]);
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid[i] && CW'(rank[i]) == count - CW'(1)) os_c = SW'(i);
    end
  end

  assign sts.op = r.op;
  assign sts.hit = hit;
  assign sts.full = full;
  assign sts.oversize = r.piece_size > budget;
  assign sts.over_budget = bytes > {1'b0, budget};
  assign sts.empty = (valid == '0);

  assign no_slot = (cmd.kind == K_MISS || cmd.kind == K_REJECT || cmd.kind == K_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      bytes <= '0;
      hits <= '0;
      misses <= '0;
      evicts <= '0;
    end else begin
      if (cmd.load) begin
        r <= req;
        hit <= |match_c;
        hit_slot <= hs_c;
        free_slot <= fs_c;
        full <= &valid;
      end
      if (cmd.decide) begin
        if (r.op == OP_CLEAR) begin
          valid <= '0;
          bytes <= '0;
        end else if ((r.op == OP_LOOKUP || r.op == OP_INSERT) && hit) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid[i] && rank[i] < rank[hit_slot]) rank[i] <= rank[i] + SW'(1);
          end
          rank[hit_slot] <= '0;
          if (r.op == OP_LOOKUP && hits != CNT_MAX) hits <= hits + 32'd1;
          out_slot <= hit_slot;
        end else if (r.op == OP_LOOKUP) begin
          if (misses != CNT_MAX) misses <= misses + 32'd1;
        end
      end
      if (cmd.evict) begin
        valid[os_c] <= 1'b0;
        bytes <= bytes - {1'b0, size[os_c]};
        if (evicts != CNT_MAX) evicts <= evicts + 32'd1;
        out_slot <= os_c;
        free_slot <= os_c;
      end
      if (cmd.store) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid[i]) rank[i] <= rank[i] + SW'(1);
        end
        valid[free_slot] <= 1'b1;
        tag_src[free_slot] <= r.source_key;
        tag_piece[free_slot] <= r.piece_number;
        size[free_slot] <= r.piece_size;
        rank[free_slot] <= '0;
        bytes <= bytes + {1'b0, r.piece_size};
        out_slot <= free_slot;
      end
      // result register, loaded in the emit step that follows the state update it reports
      if (cmd.emit) begin
        rsp.kind <= cmd.kind;
        rsp.slot <= no_slot ? 4'd0 : 4'(out_slot);
        rsp.held_bytes <= bytes;
        rsp.held_entries <= 5'(count);
        rsp.hit_total <= hits;
        rsp.miss_total <= misses;
        rsp.eviction_total <= evicts;
        rsp.last <= cmd.last;
      end
    end
  end
endmodule

// ----- sv/lbb_ctrl.sv -----
// controller: sequences compare, update, evictions and result handshakes
`timescale 1ns / 1ps
module lbb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  lbb_pkg::sts_t  sts,
  output lbb_pkg::cmd_t  cmd
);
  import lbb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DEC   = 5'b00010,
    S_STORE = 5'b00100,
    S_CHECK = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state, state_next, ret, ret_next;
  kind_t  kind, kind_next;
  logic   fixed_last, fixed_last_next;  // result ends its item
  logic   chain, chain_next;            // insert result: last unless an eviction follows
  logic   out_v;
  logic   room;
  logic   last_c;

  assign room = !out_v || out_ready;
  assign last_c = fixed_last || (chain && !(sts.over_budget && !sts.empty));
  assign in_ready = (state == S_IDLE) && !out_v;
  assign out_valid = out_v;

  always_comb begin
    state_next = state;
    ret_next = ret;
    kind_next = kind;
    fixed_last_next = fixed_last;
    chain_next = chain;
    cmd = '0;
    cmd.kind = kind;
    cmd.last = last_c;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        fixed_last_next = 1'b1;
        chain_next = 1'b0;
        ret_next = S_IDLE;
        state_next = S_EMIT;
        case (sts.op)
          OP_LOOKUP: begin
            cmd.decide = 1'b1;
            kind_next = sts.hit ? K_HIT : K_MISS;
          end
          OP_INSERT: begin
            if (sts.hit) begin
              cmd.decide = 1'b1;
              kind_next = K_PRESENT;
            end else if (sts.oversize) begin
              kind_next = K_REJECT;
            end else if (sts.full) begin
              // full table: drop the oldest, then store
              cmd.evict = 1'b1;
              kind_next = K_EVICT;
              fixed_last_next = 1'b0;
              ret_next = S_STORE;
            end else begin
              cmd.store = 1'b1;
              kind_next = K_STORED;
              fixed_last_next = 1'b0;
              chain_next = 1'b1;
              ret_next = S_CHECK;
            end
          end
          OP_CLEAR: begin
            cmd.decide = 1'b1;
            kind_next = K_DONE;
          end
          default: begin
            fixed_last_next = 1'b0;
            state_next = S_CHECK;
          end
        endcase
      end
      S_STORE: begin
        cmd.store = 1'b1;
        kind_next = K_STORED;
        fixed_last_next = 1'b0;
        chain_next = 1'b1;
        ret_next = S_CHECK;
        state_next = S_EMIT;
      end
      S_CHECK: begin
        state_next = S_EMIT;
        ret_next = S_CHECK;
        if (sts.over_budget && !sts.empty) begin
          cmd.evict = 1'b1;
          kind_next = K_EVICT;
          fixed_last_next = 1'b0;
          chain_next = (sts.op == OP_INSERT);
        end else begin
          kind_next = K_DONE;
          fixed_last_next = 1'b1;
          chain_next = 1'b0;
        end
      end
      S_EMIT: begin
        // state already updated, so last is known here
        if (room) begin
          cmd.emit = 1'b1;
          state_next = last_c ? S_IDLE : ret;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret <= S_IDLE;
      kind <= K_DONE;
      fixed_last <= 1'b0;
      chain <= 1'b0;
      out_v <= 1'b0;
    end else begin
      state <= state_next;
      ret <= ret_next;
      kind <= kind_next;
      fixed_last <= fixed_last_next;
      chain <= chain_next;
      if (cmd.emit) out_v <= 1'b1;
      else if (out_ready) out_v <= 1'b0;
    end
  end
endmodule

// ----- test/lbb_check.sv -----
// checker: watches request and result channels, predicts results and compares
`timescale 1ns / 1ps
module lbb_check (
  input  logic        clk,
  input  logic        rst,
  lbb_req_if          req,
  lbb_rsp_if          rsp,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          result_count
);
  import lbb_pkg::*;

  // predicted cache state
  logic        tag_ok  [ENTRIES];
  logic [63:0] tag_src [ENTRIES];
  logic [31:0] tag_pc  [ENTRIES];
  logic [31:0] tag_len [ENTRIES];
  logic [3:0]  age     [ENTRIES];
  logic [32:0] bytes_held;
  logic [31:0] hits, misses, evicts, budget;
  rsp_t        want_q[$];

  function automatic logic [4:0] live_count();
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < ENTRIES; i++) if (tag_ok[i]) n++;
    return n;
  endfunction

  function automatic void push_result(kind_t k, int s);
    rsp_t r;
    r.kind = k; r.slot = s[3:0]; r.held_bytes = bytes_held;
    r.held_entries = live_count(); r.hit_total = hits; r.miss_total = misses;
    r.eviction_total = evicts; r.last = 1'b0;
    want_q.push_back(r);
  endfunction

  function automatic int find_entry(logic [63:0] src, logic [31:0] pc);
    for (int i = 0; i < ENTRIES; i++)
      if (tag_ok[i] && tag_src[i] == src && tag_pc[i] == pc) return i;
    return -1;
  endfunction

  function automatic void make_newest(int s);
    for (int i = 0; i < ENTRIES; i++)
      if (tag_ok[i] && age[i] < age[s]) age[i]++;
    age[s] = 0;
  endfunction

  function automatic int drop_oldest();
    int b;
    b = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (tag_ok[i] && (b < 0 || age[i] > age[b])) b = i;
    if (b >= 0) begin
      tag_ok[b] = 1'b0;
      bytes_held = bytes_held - {1'b0, tag_len[b]};
      if (evicts != CNT_MAX) evicts++;
    end
    return b;
  endfunction

  function automatic void shrink_to_budget();
    int s;
    while (bytes_held > {1'b0, budget}) begin
      s = drop_oldest();
      if (s < 0) break;
      push_result(K_EVICT, s);
    end
  endfunction

  function automatic void predict_item(logic [1:0] op, logic [63:0] src,
                                       logic [31:0] pc, logic [31:0] len);
    int s, f;
    s = find_entry(src, pc);
    case (op)
      OP_LOOKUP: begin
        if (s >= 0) begin
          if (hits != CNT_MAX) hits++;
          make_newest(s);
          push_result(K_HIT, s);
        end else begin
          if (misses != CNT_MAX) misses++;
          push_result(K_MISS, 0);
        end
      end
      OP_INSERT: begin
        if (s >= 0) begin
          make_newest(s);
          push_result(K_PRESENT, s);
        end else if (len > budget) begin
          push_result(K_REJECT, 0);
        end else begin
          f = -1;
          for (int i = ENTRIES - 1; i >= 0; i--) if (!tag_ok[i]) f = i;
          if (f < 0) begin
            f = drop_oldest();
            push_result(K_EVICT, f);
          end
          for (int i = 0; i < ENTRIES; i++) if (tag_ok[i]) age[i]++;
          tag_ok[f] = 1'b1; tag_src[f] = src; tag_pc[f] = pc;
          tag_len[f] = len; age[f] = 0;
          bytes_held = bytes_held + {1'b0, len};
          push_result(K_STORED, f);
          shrink_to_budget();
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) tag_ok[i] = 1'b0;
        bytes_held = 0;
        push_result(K_DONE, 0);
      end
      default: begin
        shrink_to_budget();
        push_result(K_DONE, 0);
      end
    endcase
    want_q[$].last = 1'b1;
  endfunction

  task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t w;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) tag_ok[i] = 1'b0;
      bytes_held = '0; hits = '0; misses = '0; evicts = '0;
      budget = BUDGET_RESET;
      want_q.delete();
      fail_count = 0; result_count = 0;
    end else begin
      if (cfg_we) budget = cfg_wdata;
      if (req.valid && req.ready)
        predict_item(req.op, req.source_key, req.piece_number, req.piece_size);
      if (rsp.valid && rsp.ready) begin
        result_count++;
        if (want_q.size() == 0) begin
          $error("result with nothing expected: kind %0d", rsp.kind);
          fail_count++;
        end else begin
          w = want_q.pop_front();
          compare_field("kind", w.kind, rsp.kind);
          compare_field("slot", w.slot, rsp.slot);
          compare_field("held_bytes", w.held_bytes, rsp.held_bytes);
          compare_field("held_entries", w.held_entries, rsp.held_entries);
          compare_field("hit_total", w.hit_total, rsp.hit_total);
          compare_field("miss_total", w.miss_total, rsp.miss_total);
          compare_field("eviction_total", w.eviction_total, rsp.eviction_total);
          compare_field("last", w.last, rsp.last);
        end
      end
    end
    pending = want_q.size();
  end
endmodule

// ----- test/tb_top.sv -----
// testbench top: stimulus, idling, budget phases and verdict for the lru policy engine
`timescale 1ns / 1ps
module tb_top;
  import lbb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  int          fail_count, pending, result_count;
  int          cycles = 0;
  int          items_sent = 0;
  int          gap_left = 0;
  bit          quiet = 1'b0;

  lbb_req_if req ();
  lbb_rsp_if rsp ();

  lru_byte_budget_cache_policy u_top (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  lbb_check u_check (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  always #10 clk = ~clk;

  // small pools of tags so lookups and refreshes actually hit
  logic [63:0] src_pool [4] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
                                64'hA5A5_5A5A_0F0F_F0F0, 64'h1234_5678_9ABC_DEF0};

  // result side: random stall bursts, none once quiet
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (quiet) begin
      rsp.ready <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      rsp.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      gap_left <= $urandom_range(0, 5);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // cycle limit watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one item through the handshake, with an optional idle burst first
  task automatic send_item(op_t op, logic [63:0] src, logic [31:0] pc, logic [31:0] len);
    int idle;
    idle = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 0;
    if (idle > 0) begin
      req.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    req.valid <= 1'b1; req.op <= op; req.source_key <= src;
    req.piece_number <= pc; req.piece_size <= len;
    do @(posedge clk); while (!req.ready);
    items_sent++;
  endtask

  // hold off until every expected result is in
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_budget(logic [31:0] b);
    drain();
    cfg_we <= 1'b1; cfg_wdata <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random item, mostly over a small tag space so the lru order gets exercised
  task automatic random_item(logic [31:0] size_cap);
    op_t         op;
    logic [63:0] src;
    logic [31:0] pc;
    logic [31:0] len;
    int          r;
    r = $urandom_range(0, 99);
    op = r < 40 ? OP_LOOKUP : r < 85 ? OP_INSERT : r < 90 ? OP_CLEAR : OP_TRIM;
    if ($urandom_range(0, 9) == 0) begin
      src = {$urandom, $urandom};
      pc = $urandom;
    end else begin
      src = src_pool[$urandom_range(0, 3)];
      pc = $urandom_range(0, 23);
    end
    len = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, size_cap);
    send_item(op, src, pc, len);
  endtask

  initial begin
    req.valid = 1'b0; req.op = '0; req.source_key = '0;
    req.piece_number = '0; req.piece_size = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, every op, oversize reject, zero size
    send_item(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_item(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_item(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd5);
    send_item(OP_INSERT, 64'h0, 32'h0, 32'hFFFF_FFFF);   // oversize reject
    send_item(OP_INSERT, 64'h0, 32'h0, BUDGET_RESET);    // exactly budget
    send_item(OP_INSERT, 64'h1, 32'h1, 32'd1);           // pushes over budget
    // overfill the table so the full-table eviction fires
    for (int i = 0; i < 18; i++) send_item(OP_INSERT, 64'h77, i, 32'd3);
    send_item(OP_TRIM, 64'h0, 32'h0, 32'h0);
    send_item(OP_CLEAR, 64'h0, 32'h0, 32'h0);

    // budget phases, extremes among them; the sender waits for drain at each
    set_budget(32'hFFFF_FFFF);
    for (int i = 0; i < 100; i++) random_item(32'hFFFF_FFFF);
    set_budget(32'd40);
    send_item(OP_TRIM, 64'h0, 32'h0, 32'h0);
    for (int i = 0; i < 120; i++) random_item(32'd16);
    set_budget(32'd0);
    for (int i = 0; i < 30; i++) random_item(32'd2);
    set_budget(32'd1000);
    for (int i = 0; i < 80; i++) random_item(32'd300);
    quiet = 1'b1;
    set_budget(BUDGET_RESET);
    for (int i = 0; i < 70; i++) random_item(32'hFF_FFFF);

    drain();
    $display("sent %0d items, checked %0d results over five budget settings",
             items_sent, result_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
